// ===== hdl/jbt_pkg.sv =====
// Shared types, constants and helper functions for the JSON byte tokenizer.
package jbt_pkg;

	// Width of the internal byte offset counters and the nesting limit.
	localparam int POSITION_BITS = 16;
	localparam int MAX_DEPTH     = 255;
	localparam int DEPTH_BITS    = $clog2(MAX_DEPTH + 1);

	// Output queue geometry.
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

	// Token kinds.
	localparam logic [3:0] K_NUMBER = 4'd0;
	localparam logic [3:0] K_STRING = 4'd1;
	localparam logic [3:0] K_NULL   = 4'd2;
	localparam logic [3:0] K_BOOL   = 4'd3;
	localparam logic [3:0] K_OBJECT = 4'd4;
	localparam logic [3:0] K_ARRAY  = 4'd5;
	localparam logic [3:0] K_CLOSE  = 4'd6;
	localparam logic [3:0] K_ERROR  = 4'd7;
	localparam logic [3:0] K_END    = 4'd8;

	// Error codes.
	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_BAD_CHAR = 3'd1;
	localparam logic [2:0] E_EARLY    = 3'd2;
	localparam logic [2:0] E_CLOSE    = 3'd3;
	localparam logic [2:0] E_DEPTH    = 3'd4;
	localparam logic [2:0] E_LONG     = 3'd5;

	// Literal kinds and their spellings.
	localparam logic [1:0] LIT_NULL  = 2'd0;
	localparam logic [1:0] LIT_TRUE  = 2'd1;
	localparam logic [1:0] LIT_FALSE = 2'd2;

	localparam logic [7:0] LIT_TEXT [3][5] = '{
		'{8'h6e, 8'h75, 8'h6c, 8'h6c, 8'h00},
		'{8'h74, 8'h72, 8'h75, 8'h65, 8'h00},
		'{8'h66, 8'h61, 8'h6c, 8'h73, 8'h65}
	};
	localparam logic [2:0] LIT_LEN [3] = '{3'd4, 3'd4, 3'd5};

	// One input item.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_data;
	} jbt_text_t;

	// One result item.
	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] start_offset;
		logic [15:0] end_offset;
		logic [7:0]  nest_depth;
		logic        bool_true;
		logic [2:0]  error_code;
		logic        last_of_run;
	} jbt_token_t;

	// Tokens produced by one step, handed from the scanner to the output queue.
	typedef struct packed {
		logic [1:0] count;
		jbt_token_t tok0;
		jbt_token_t tok1;
	} jbt_push_t;

	// Character of a literal at a given index, zero past its end.
	function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		if (k != 2'd3 && i < 3'd5) begin
			c = LIT_TEXT[k][i];
		end
		return c;
	endfunction

	// Length of a literal.
	function automatic logic [2:0] lit_len(input logic [1:0] k);
		logic [2:0] len;
		len = LIT_LEN[0];
		if (k != 2'd3) begin
			len = LIT_LEN[k];
		end
		return len;
	endfunction

	// Build a token from internal offsets and depth, keeping their low bits.
	function automatic jbt_token_t make_tok(
		input logic [3:0]               kind,
		input logic [POSITION_BITS-1:0] s,
		input logic [POSITION_BITS-1:0] e,
		input logic [DEPTH_BITS-1:0]    d,
		input logic                     bt,
		input logic [2:0]               err
	);
		jbt_token_t t;
		logic [31:0] s32;
		logic [31:0] e32;
		logic [31:0] d32;
		s32 = 32'(s);
		e32 = 32'(e);
		d32 = 32'(d);
		t.token_kind   = kind;
		t.start_offset = s32[15:0];
		t.end_offset   = e32[15:0];
		t.nest_depth   = d32[7:0];
		t.bool_true    = bt;
		t.error_code   = err;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

endpackage

// ===== hdl/jbt_scan.sv =====
// Tokenizer scanner: scan state and the per-byte state update.
module jbt_scan
	import jbt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  jbt_text_t text_s1,
	output jbt_push_t push
);

	typedef enum logic [5:0] {
		M_IDLE    = 6'b000001,
		M_NUMBER  = 6'b000010,
		M_STRING  = 6'b000100,
		M_ESCAPE  = 6'b001000,
		M_LITERAL = 6'b010000,
		M_ERROR   = 6'b100000
	} jbt_mode_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_E_LO   = 8'h65;
	localparam logic [7:0] CH_E_UP   = 8'h45;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [DEPTH_BITS-1:0] DEPTH_LIMIT = DEPTH_BITS'(MAX_DEPTH);

	// Scan state.
	jbt_mode_t                mode_q;
	logic [1:0]               lk_q;
	logic [2:0]               li_q;
	logic [POSITION_BITS-1:0] ts_q;
	logic [POSITION_BITS-1:0] bp_q;
	logic [DEPTH_BITS-1:0]    depth_q;
	logic [2:0]               err_q;

	jbt_mode_t                mode_d;
	logic [1:0]               lk_d;
	logic [2:0]               li_d;
	logic [POSITION_BITS-1:0] ts_d;
	logic [POSITION_BITS-1:0] bp_d;
	logic [DEPTH_BITS-1:0]    depth_d;
	logic [2:0]               err_d;

	// Results of treating the current byte as the start of a new token.
	jbt_mode_t                id_mode;
	logic [1:0]               id_lk;
	logic [2:0]               id_li;
	logic [POSITION_BITS-1:0] id_ts;
	logic [DEPTH_BITS-1:0]    id_depth;
	logic [2:0]               id_code;
	logic                     id_emit;
	jbt_token_t               id_tok;

	logic [7:0] b;
	logic       is_digit;
	logic       is_num;
	logic       pos_full;
	logic [1:0] lit_k;
	logic [7:0] lit_c;
	logic [2:0] lit_n;
	logic       lit_bad;
	logic       lit_done;
	logic       eod_bad;
	logic [1:0] cnt;
	jbt_token_t t0;
	jbt_token_t t1;

	assign b        = text_s1.text_byte;
	assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	assign is_num   = is_digit || b == CH_MINUS || b == CH_PLUS || b == CH_E_LO ||
		b == CH_E_UP || b == CH_DOT;
	assign pos_full = &bp_q;

	// Literal match against the expected character.
	assign lit_k    = (lk_q == 2'd3) ? LIT_NULL : lk_q;
	assign lit_c    = lit_char(lit_k, li_q);
	assign lit_n    = lit_len(lit_k);
	assign lit_bad  = (li_q >= lit_n) || (lit_c != b);
	assign lit_done = ({1'b0, li_q} + 4'd1) == {1'b0, lit_n};
	assign eod_bad  = (mode_q != M_IDLE && mode_q != M_NUMBER) || depth_q != '0;

	// Byte seen between tokens.
	always_comb begin
		id_mode  = M_IDLE;
		id_lk    = lk_q;
		id_li    = li_q;
		id_ts    = ts_q;
		id_depth = depth_q;
		id_code  = E_NONE;
		id_emit  = 1'b0;
		id_tok   = '0;
		case (b)
			CH_SPACE, CH_LF, CH_CR, CH_TAB, CH_COLON, CH_COMMA: begin
			end
			CH_QUOTE: begin
				id_ts   = bp_q + 1'b1;
				id_mode = M_STRING;
			end
			CH_LBRACE, CH_LBRACK: begin
				if (depth_q >= DEPTH_LIMIT) begin
					id_code = E_DEPTH;
				end else begin
					id_depth = depth_q + 1'b1;
					id_emit  = 1'b1;
					id_tok   = make_tok((b == CH_LBRACE) ? K_OBJECT : K_ARRAY, bp_q,
						bp_q + 1'b1, depth_q + 1'b1, 1'b0, E_NONE);
				end
			end
			CH_RBRACE, CH_RBRACK: begin
				if (depth_q == '0) begin
					id_code = E_CLOSE;
				end else begin
					id_depth = depth_q - 1'b1;
					id_emit  = 1'b1;
					id_tok   = make_tok(K_CLOSE, bp_q, bp_q + 1'b1, depth_q - 1'b1,
						1'b0, E_NONE);
				end
			end
			CH_N, CH_T, CH_F: begin
				id_lk   = (b == CH_N) ? LIT_NULL : (b == CH_T) ? LIT_TRUE : LIT_FALSE;
				id_li   = 3'd1;
				id_ts   = bp_q;
				id_mode = M_LITERAL;
			end
			default: begin
				if (b == CH_MINUS || is_digit) begin
					id_ts   = bp_q;
					id_mode = M_NUMBER;
				end else begin
					id_code = E_BAD_CHAR;
				end
			end
		endcase
		if (id_code != E_NONE) begin
			id_mode = M_ERROR;
			id_ts   = bp_q;
			id_emit = 1'b1;
			id_tok  = make_tok(K_ERROR, bp_q, bp_q, depth_q, 1'b0, id_code);
		end
	end

	// Next state and the tokens of this step.
	always_comb begin
		mode_d  = mode_q;
		lk_d    = lk_q;
		li_d    = li_q;
		ts_d    = ts_q;
		bp_d    = bp_q;
		depth_d = depth_q;
		err_d   = err_q;
		cnt     = 2'd0;
		t0      = '0;
		t1      = '0;
		if (mode_q == M_ERROR) begin
			// Sticky error: repeat the stored error token.
			cnt = 2'd1;
			t0  = make_tok(K_ERROR, ts_q, ts_q, depth_q, 1'b0, err_q);
		end else if (text_s1.end_of_data) begin
			// End mark: flush a pending number, then end or early-end error.
			if (mode_q == M_NUMBER) begin
				cnt = 2'd2;
				t0  = make_tok(K_NUMBER, ts_q, bp_q, depth_q, 1'b0, E_NONE);
				t1  = eod_bad ? make_tok(K_ERROR, bp_q, bp_q, depth_q, 1'b0, E_EARLY)
					: make_tok(K_END, bp_q, bp_q, depth_q, 1'b0, E_NONE);
			end else begin
				cnt = 2'd1;
				t0  = eod_bad ? make_tok(K_ERROR, bp_q, bp_q, depth_q, 1'b0, E_EARLY)
					: make_tok(K_END, bp_q, bp_q, depth_q, 1'b0, E_NONE);
			end
			if (eod_bad) begin
				mode_d = M_ERROR;
				err_d  = E_EARLY;
				ts_d   = bp_q;
			end else begin
				mode_d = M_IDLE;
				bp_d   = '0;
				ts_d   = '0;
				lk_d   = LIT_NULL;
				li_d   = 3'd0;
			end
		end else if (pos_full) begin
			// Offset counter exhausted.
			cnt    = 2'd1;
			t0     = make_tok(K_ERROR, bp_q, bp_q, depth_q, 1'b0, E_LONG);
			mode_d = M_ERROR;
			err_d  = E_LONG;
			ts_d   = bp_q;
		end else begin
			case (mode_q)
				M_NUMBER: begin
					if (!is_num) begin
						t0      = make_tok(K_NUMBER, ts_q, bp_q, depth_q, 1'b0, E_NONE);
						t1      = id_tok;
						cnt     = id_emit ? 2'd2 : 2'd1;
						mode_d  = id_mode;
						lk_d    = id_lk;
						li_d    = id_li;
						ts_d    = id_ts;
						depth_d = id_depth;
						if (id_mode == M_ERROR) begin
							err_d = id_code;
						end
					end
				end
				M_STRING: begin
					if (b == CH_BSLASH) begin
						mode_d = M_ESCAPE;
					end else if (b == CH_QUOTE) begin
						cnt    = 2'd1;
						t0     = make_tok(K_STRING, ts_q, bp_q, depth_q, 1'b0, E_NONE);
						mode_d = M_IDLE;
					end
				end
				M_ESCAPE: begin
					mode_d = M_STRING;
				end
				M_LITERAL: begin
					if (lit_bad) begin
						cnt    = 2'd1;
						t0     = make_tok(K_ERROR, bp_q, bp_q, depth_q, 1'b0, E_BAD_CHAR);
						mode_d = M_ERROR;
						err_d  = E_BAD_CHAR;
						ts_d   = bp_q;
					end else if (lit_done) begin
						cnt    = 2'd1;
						t0     = make_tok((lit_k == LIT_NULL) ? K_NULL : K_BOOL, ts_q,
							bp_q + 1'b1, depth_q, lit_k == LIT_TRUE, E_NONE);
						mode_d = M_IDLE;
						li_d   = 3'd0;
					end else begin
						li_d = li_q + 1'b1;
					end
				end
				M_IDLE: begin
					t0      = id_tok;
					cnt     = id_emit ? 2'd1 : 2'd0;
					mode_d  = id_mode;
					lk_d    = id_lk;
					li_d    = id_li;
					ts_d    = id_ts;
					depth_d = id_depth;
					if (id_mode == M_ERROR) begin
						err_d = id_code;
					end
				end
				default: begin
				end
			endcase
			if (mode_d != M_ERROR) begin
				bp_d = bp_q + 1'b1;
			end
		end
		// Mark the final token of the step.
		if (cnt == 2'd1) begin
			t0.last_of_run = 1'b1;
		end
		if (cnt == 2'd2) begin
			t1.last_of_run = 1'b1;
		end
	end

	// Tokens go to the output queue only on a step.
	always_comb begin
		push.count = step ? cnt : 2'd0;
		push.tok0  = t0;
		push.tok1  = t1;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			lk_q    <= LIT_NULL;
			li_q    <= 3'd0;
			ts_q    <= '0;
			bp_q    <= '0;
			depth_q <= '0;
			err_q   <= E_NONE;
		end else if (step) begin
			mode_q  <= mode_d;
			lk_q    <= lk_d;
			li_q    <= li_d;
			ts_q    <= ts_d;
			bp_q    <= bp_d;
			depth_q <= depth_d;
			err_q   <= err_d;
		end
	end

`ifndef SYNTHESIS
	// Once an error is taken, the scanner stays in error until reset.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_ERROR |=> mode_q == M_ERROR)
		else $error("scanner left the error state");

	// The nesting depth never passes its limit.
	a_depth_limit: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_LIMIT)
		else $error("nesting depth above limit");
`endif

endmodule

// ===== hdl/jbt_fifo.sv =====
// Output token queue: takes up to two tokens per cycle, gives one per cycle.
module jbt_fifo
	import jbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  jbt_push_t  push,
	input  logic       pop,
	output logic       room,
	output logic       not_empty,
	output jbt_token_t head
);

	jbt_token_t               entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_q;
	logic [FIFO_PTR_BITS-1:0] rd_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic [FIFO_PTR_BITS-1:0] wr_next;

	// Pointer increment with wrap at the queue depth.
	function automatic logic [FIFO_PTR_BITS-1:0] ptr_inc(input logic [FIFO_PTR_BITS-1:0] p);
		logic [FIFO_PTR_BITS-1:0] r;
		r = (p == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign wr_next   = ptr_inc(wr_q);
	assign room      = count_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_q];

	// Token storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_q] <= push.tok0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_next] <= push.tok1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.count == 2'd1) begin
				wr_q <= wr_next;
			end else if (push.count == 2'd2) begin
				wr_q <= ptr_inc(wr_next);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			count_q <= count_q + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
		end
	end

`ifndef SYNTHESIS
	// The queue never holds more tokens than it has entries.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("token queue overflow");
`endif

endmodule

// ===== hdl/json_byte_tokenizer_top.sv =====
// Top level of the streaming JSON byte tokenizer.
//
// The tokenizer takes one byte of JSON text per transfer on the text channel
// and gives zero, one or two tokens per byte on the token channel, in order,
// the last of each group marked by last_of_run. A byte is first held in an
// input register and is scanned once the output queue has room for two tokens,
// when its tokens are written into a four-entry output queue; a token is
// therefore presented after its byte has passed the input register and the
// queue. The block takes one byte every cycle as long as the output queue has
// room for two tokens, so the sustained rate is one byte per cycle when tokens
// are taken as they appear; a byte that gives a token pair needs one transfer
// per token on the token port, which then sets the rate. Errors are sticky
// until reset, and an end-of-data transfer that closes a well-formed document
// starts a new one at offset zero.
module json_byte_tokenizer_top
	import jbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_ready,
	input  jbt_text_t  text,
	output logic       token_valid,
	input  logic       token_ready,
	output jbt_token_t token
);

	logic      valid_s1;
	jbt_text_t text_s1;
	logic      room;
	logic      step;
	logic      pop;
	jbt_push_t push;

	// A held byte is scanned when the queue can take two tokens.
	assign step       = valid_s1 && room;
	assign text_ready = !valid_s1 || step;
	assign pop        = token_valid && token_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && text_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			text_s1 <= text;
		end
	end

	// Scanner state and per-byte update.
	jbt_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.text_s1 (text_s1),
		.push    (push)
	);

	// Output token queue.
	jbt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.room      (room),
		.not_empty (token_valid),
		.head      (token)
	);

`ifndef SYNTHESIS
	// A held byte that cannot be scanned stays in the input register unchanged.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> (valid_s1 && $stable(text_s1)))
		else $error("held byte lost before scan");
`endif

endmodule
